// ===== hdl/assert_macros.svh =====
// Assertion helpers, clocked on i_clk and held off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/lprc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lprc_pkg;

    localparam int PAGE_W        = 16;   // page port width
    localparam int IDX_W         = 4;    // frame index / age rank width
    localparam int CNT_W         = 16;   // fault counter width
    localparam int FRAMES_DEF    = 3;
    localparam int PAGE_BITS_DEF = 16;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // Forward chain: first-match search and fill position.
    typedef struct packed {
        logic             hit_seen;    // some earlier cell matched
        logic [IDX_W-1:0] hit_age;     // age rank of the matching cell
        logic             valid_prev;  // previous cell holds a page
    } t_chain;

    // Broadcast from the top level to every cell while a request is processed.
    typedef struct packed {
        logic             active;
        logic             eos;
        logic             any_hit;
        logic             full;
        logic [IDX_W-1:0] hit_age;
    } t_bcast;

endpackage

`default_nettype wire

// ===== hdl/lprc_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One frame: page, valid flag and LRU age rank (0 = most recent).
module lprc_cell import lprc_pkg::*; #(
    parameter int IDX    = 0,
    parameter int FRAMES = FRAMES_DEF,
    parameter int P_W    = PAGE_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_bcast           i_bcast,
    input  wire logic [P_W-1:0]   i_page,
    input  wire t_chain           i_chain,
    output t_chain                o_chain,
    input  wire logic [IDX_W-1:0] i_idx,
    output logic      [IDX_W-1:0] o_idx,
    input  wire logic [P_W-1:0]   i_vic,
    output logic      [P_W-1:0]   o_vic,
    output logic                  o_sel
);

    localparam int REC_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    logic             r_valid;
    logic [REC_W-1:0] r_rec;
    logic [P_W-1:0]   r_page;

    logic             w_match;
    logic             w_hit_here;
    logic             w_fill_here;
    logic             w_victim_here;
    logic [IDX_W-1:0] w_rec4;

    always_comb begin
        w_rec4        = IDX_W'(r_rec);
        w_match       = r_valid && (r_page == i_page);
        w_hit_here    = w_match && !i_chain.hit_seen;
        w_fill_here   = !r_valid && i_chain.valid_prev;
        w_victim_here = r_valid && (w_rec4 == IDX_W'(FRAMES - 1));

        o_chain.hit_seen   = i_chain.hit_seen | w_match;
        o_chain.hit_age    = i_chain.hit_age | (w_hit_here ? w_rec4 : '0);
        o_chain.valid_prev = r_valid;

        if (i_bcast.any_hit) begin
            o_sel = i_bcast.active && w_hit_here;
        end else if (i_bcast.full) begin
            o_sel = i_bcast.active && w_victim_here;
        end else begin
            o_sel = i_bcast.active && w_fill_here;
        end

        o_idx = i_idx | (o_sel ? IDX_W'(IDX) : '0);
        o_vic = i_vic | ((o_sel && !i_bcast.any_hit && i_bcast.full) ? r_page : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rec   <= '0;
        end else if (i_bcast.active) begin
            if (i_bcast.eos) begin
                r_valid <= 1'b0;
                r_rec   <= '0;
            end else if (o_sel) begin
                r_valid <= 1'b1;
                r_rec   <= '0;
            end else if (r_valid && (!i_bcast.any_hit || (w_rec4 < i_bcast.hit_age))) begin
                r_rec <= r_rec + REC_W'(1);
            end
        end
    end

    // Page store: written on a miss into this frame, no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_bcast.active && o_sel && !i_bcast.any_hit) begin
            r_page <= i_page;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lru_page_replacement_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Direction | Handshake              | Payload
// ----------+-----------+------------------------+---------------------------------------
// request   | in        | start & !busy          | i_page, i_end_of_string
// result    | out       | o_strobe (one cycle)   | o_fault, o_frame_index, o_evicted,
//           |           |                        | o_evicted_page, o_fault_count
//
// Each request is registered, passes through the chain of frame cells
// (match, fill/victim pick, age update), and its result is registered.
// busy is high for the one cycle the chain is working; a new request can be
// taken in the cycle its predecessor's result is on the ports.
// Synchronous active-low reset empties all frames and clears the fault count.
// The receiver cannot stall; each result shows for exactly one cycle.
module lru_page_replacement_top import lprc_pkg::*; #(
    parameter int FRAMES    = FRAMES_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [PAGE_W-1:0] i_page,
    input  wire logic              i_end_of_string,
    output logic                   o_strobe,
    output logic                   o_fault,
    output logic [IDX_W-1:0]       o_frame_index,
    output logic                   o_evicted,
    output logic [PAGE_W-1:0]      o_evicted_page,
    output logic [CNT_W-1:0]       o_fault_count
);

`include "assert_macros.svh"

    // Stored page width: bits above PAGE_BITS are ignored.
    localparam int P_W = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;

    // Registered request
    logic             r_busy;
    logic [P_W-1:0]   r_page;
    logic             r_eos;
    logic [CNT_W-1:0] r_fault_total;

    // Registered result
    logic              r_strobe;
    logic              r_fault;
    logic [IDX_W-1:0]  r_frame_index;
    logic              r_evicted;
    logic [PAGE_W-1:0] r_evicted_page;
    logic [CNT_W-1:0]  r_fault_count;

    logic [CNT_W-1:0]  n_fault_total;

    // Cell chains
    t_chain           w_chain [0:FRAMES];
    logic [IDX_W-1:0] w_idx   [0:FRAMES];
    logic [P_W-1:0]   w_vic   [0:FRAMES];
    logic [FRAMES-1:0] w_sel;
    t_bcast           w_bcast;

    assign w_chain[0] = '{hit_seen: 1'b0, hit_age: '0, valid_prev: 1'b1};
    assign w_idx[0]   = '0;
    assign w_vic[0]   = '0;

    // Chain end tells every cell whether it was a hit and whether frames are full.
    always_comb begin
        w_bcast.active  = r_busy;
        w_bcast.eos     = r_eos;
        w_bcast.any_hit = w_chain[FRAMES].hit_seen;
        w_bcast.full    = w_chain[FRAMES].valid_prev;
        w_bcast.hit_age = w_chain[FRAMES].hit_age;
    end

    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        lprc_cell #(
            .IDX    (g),
            .FRAMES (FRAMES),
            .P_W    (P_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bcast (w_bcast),
            .i_page  (r_page),
            .i_chain (w_chain[g]),
            .o_chain (w_chain[g+1]),
            .i_idx   (w_idx[g]),
            .o_idx   (w_idx[g+1]),
            .i_vic   (w_vic[g]),
            .o_vic   (w_vic[g+1]),
            .o_sel   (w_sel[g])
        );
    end

    // Running fault count, saturating; includes this request.
    always_comb begin
        if (w_bcast.any_hit || (r_fault_total == COUNT_MAX)) begin
            n_fault_total = r_fault_total;
        end else begin
            n_fault_total = r_fault_total + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b0;
            r_strobe      <= 1'b0;
            r_fault_total <= '0;
        end else begin
            r_strobe <= r_busy;
            if (r_busy) begin
                r_busy        <= 1'b0;
                r_fault_total <= r_eos ? '0 : n_fault_total;
            end else if (start) begin
                r_busy <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (start && !r_busy) begin
            r_page <= i_page[P_W-1:0];
            r_eos  <= i_end_of_string;
        end
        if (r_busy) begin
            r_fault        <= !w_bcast.any_hit;
            r_frame_index  <= w_idx[FRAMES];
            r_evicted      <= !w_bcast.any_hit && w_bcast.full;
            r_evicted_page <= PAGE_W'(w_vic[FRAMES]);
            r_fault_count  <= n_fault_total;
        end
    end

    assign busy           = r_busy;
    assign o_strobe       = r_strobe;
    assign o_fault        = r_fault;
    assign o_frame_index  = r_frame_index;
    assign o_evicted      = r_evicted;
    assign o_evicted_page = r_evicted_page;
    assign o_fault_count  = r_fault_count;

    // Every request picks exactly one frame.
    `CHK_NOW(a_one_frame, r_busy, $onehot(w_sel), "request did not select exactly one frame")
    // A result follows every working cycle.
    `CHK_NEXT(a_result_follows, r_busy, o_strobe, "missing result after chain pass")
    // An eviction only ever comes with a fault.
    `CHK_NOW(a_evict_is_fault, o_strobe && o_evicted, o_fault, "eviction reported on a hit")

endmodule

`default_nettype wire

// ===== tb/lru_page_replacement_top_tb.sv =====
`timescale 1ns / 1ps

module lru_page_replacement_top_tb;
    import lprc_pkg::*;

    localparam int FRAMES         = FRAMES_DEF;
    localparam int PAGE_BITS      = PAGE_BITS_DEF;
    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 4;
    localparam int MAX_GAP        = 13;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 400;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_ITEMS   = 930;
    localparam int MISS_RUN       = 200;

    // Page bits above PAGE_BITS never take part in matching or storing.
    localparam logic [PAGE_W-1:0] PAGE_MASK = (PAGE_BITS >= PAGE_W) ? {PAGE_W{1'b1}} :
                                              ({PAGE_W{1'b1}} >> (PAGE_W - PAGE_BITS));

    // How a random string picks its working set of pages.
    typedef enum int {
        POOL_WIDE,      // anywhere in the page space
        POOL_NARROW,    // a handful of low page numbers
        POOL_EXTREME,   // all-zero / all-one pages mixed with random ones
        POOL_NEIGHBOR   // pages one bit apart, to stress the compare
    } t_pool_style;

    typedef struct packed {
        logic              fault;
        logic [IDX_W-1:0]  frame_index;
        logic              evicted;
        logic [PAGE_W-1:0] evicted_page;
        logic [CNT_W-1:0]  fault_count;
    } t_lru_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [PAGE_W-1:0] i_page;
    logic              i_end_of_string;
    logic              o_strobe;
    logic              o_fault;
    logic [IDX_W-1:0]  o_frame_index;
    logic              o_evicted;
    logic [PAGE_W-1:0] o_evicted_page;
    logic [CNT_W-1:0]  o_fault_count;

    // Shadow copy of the frame table kept by the predictor.
    logic [PAGE_W-1:0] lru_page [FRAMES];
    logic [IDX_W-1:0]  lru_age  [FRAMES];   // 0 = most recently used
    int                lru_filled;
    logic [CNT_W-1:0]  lru_faults;

    t_lru_result pending_results[$];   // predicted results, oldest first
    int          error_count;
    int          idle_cycles;
    bit          no_idle;              // when set, requests go back to back

    lru_page_replacement_top #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_page          (i_page),
        .i_end_of_string (i_end_of_string),
        .o_strobe        (o_strobe),
        .o_fault         (o_fault),
        .o_frame_index   (o_frame_index),
        .o_evicted       (o_evicted),
        .o_evicted_page  (o_evicted_page),
        .o_fault_count   (o_fault_count)
    );

    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Frame t becomes most recent; frames younger than its old rank age by one.
    function void promote_frame(input int t, input logic [IDX_W-1:0] old_age);
        for (int j = 0; j < lru_filled; j++) begin
            if (j != t && lru_age[j] < old_age)
                lru_age[j] = lru_age[j] + 1'b1;
        end
        lru_age[t] = '0;
    endfunction

    // Applies one page request to the shadow table and returns its result.
    function automatic t_lru_result predict_lru(input logic [PAGE_W-1:0] page,
                                                input logic eos);
        t_lru_result       r;
        logic [PAGE_W-1:0] pg;
        logic              hit;
        int                target;
        logic [IDX_W-1:0]  old_age;

        r      = '0;
        pg     = page & PAGE_MASK;
        hit    = 1'b0;
        target = 0;

        // first matching frame wins
        for (int j = 0; j < lru_filled; j++) begin
            if (!hit && lru_page[j] == pg) begin
                hit    = 1'b1;
                target = j;
            end
        end

        if (hit) begin
            promote_frame(target, lru_age[target]);
        end else begin
            if (lru_filled < FRAMES) begin
                // fill next empty frame; every resident frame gets older
                target  = lru_filled;
                old_age = lru_filled[IDX_W-1:0];
                lru_filled++;
                lru_age[target] = '0;
                promote_frame(target, old_age);
            end else begin
                // oldest frame goes, lowest index on a tie
                target = 0;
                for (int j = 1; j < FRAMES; j++) begin
                    if (lru_age[j] > lru_age[target])
                        target = j;
                end
                r.evicted      = 1'b1;
                r.evicted_page = lru_page[target];
                promote_frame(target, lru_age[target]);
            end
            lru_page[target] = pg;
            if (lru_faults != COUNT_MAX)
                lru_faults++;
            r.fault = 1'b1;
        end

        r.frame_index = target[IDX_W-1:0];
        r.fault_count = lru_faults;

        // end of string: result is already formed, then the table empties
        if (eos) begin
            lru_filled = 0;
            foreach (lru_age[j])
                lru_age[j] = '0;
            lru_faults = '0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------

    // Waits a random gap (none if no_idle), presents one request at the falling
    // edge, holds it until the block takes it and queues the expectation on acceptance.
    task automatic send_reference(input logic [PAGE_W-1:0] page, input logic eos);
        int gap;

        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start           = 1'b1;
        i_page          = page;
        i_end_of_string = eos;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(predict_lru(page, eos));
    endtask

    // ------------------------------------------------------------------
    // Result checker: every strobe must match the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_lru_result got;
        t_lru_result want;

        if (i_rst_n && o_strobe) begin
            got = '{o_fault, o_frame_index, o_evicted, o_evicted_page, o_fault_count};
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: result with no request pending: fault=%0b frame=%0d",
                             $time, got.fault, got.frame_index);
            end else begin
                want = pending_results.pop_front();
                if (got.fault !== want.fault || got.frame_index !== want.frame_index ||
                    got.evicted !== want.evicted || got.evicted_page !== want.evicted_page ||
                    got.fault_count !== want.fault_count) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("%0t: mismatch (exp/act) fault %0b/%0b frame %0d/%0d",
                                 $time, want.fault, got.fault,
                                 want.frame_index, got.frame_index);
                        $display("    evicted %0b/%0b evicted_page %h/%h fault_count %0d/%0d",
                                 want.evicted, got.evicted,
                                 want.evicted_page, got.evicted_page,
                                 want.fault_count, got.fault_count);
                    end
                end
            end
        end
    end

    // Watchdog: ends the run if neither a request nor a result moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Very first request after reset: miss into frame 0, count 1.
    task automatic test_first_reference;
        send_reference(16'hFFFF, 1'b0);
    endtask

    // Fill the remaining frames, then hit the oldest page three times in turn.
    task automatic test_fill_and_hit;
        send_reference(16'h0000, 1'b0);
        send_reference(16'hA5A5, 1'b0);
        send_reference(16'hFFFF, 1'b0);
        send_reference(16'h0000, 1'b0);
        send_reference(16'hA5A5, 1'b0);
    endtask

    // Misses with all frames full replace the least recently used page.
    task automatic test_lru_eviction;
        send_reference(16'h5A5A, 1'b0);
        send_reference(16'h0001, 1'b0);
        send_reference(16'hA5A5, 1'b0);
        send_reference(16'h8000, 1'b0);
        send_reference(16'h7FFF, 1'b0);
        send_reference(16'h0001, 1'b0);
        send_reference(16'hFFFE, 1'b0);
    endtask

    // End mark on a hit, on a one-request string and on an eviction.
    task automatic test_end_of_string;
        send_reference(16'h0001, 1'b1);
        send_reference(16'h0001, 1'b0);   // same page again: table was cleared
        send_reference(16'h1234, 1'b1);
        send_reference(16'h1234, 1'b1);
        send_reference(16'h0F0F, 1'b0);
        send_reference(16'hF0F0, 1'b0);
        send_reference(16'h3C3C, 1'b0);
        send_reference(16'hC3C3, 1'b1);
    endtask

    // Strings drawn from small working sets so hits, fills and evictions all
    // occur; some requests are out-of-set noise and some strings run on
    // without an end mark.
    task automatic test_random_strings;
        logic [PAGE_W-1:0] pool [8];
        logic [PAGE_W-1:0] base;
        logic [PAGE_W-1:0] pg;
        t_pool_style       style;
        int                sent;
        int                len;
        int                pool_n;
        logic              eos;

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            len    = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3)
                                                 : $urandom_range(4, 40);
            pool_n = $urandom_range(1, 6);
            style  = t_pool_style'($urandom_range(0, 3));
            base   = PAGE_W'($urandom_range(0, 16'hFFFF));
            for (int k = 0; k < pool_n; k++) begin
                case (style)
                    POOL_WIDE:     pool[k] = PAGE_W'($urandom_range(0, 16'hFFFF));
                    POOL_NARROW:   pool[k] = PAGE_W'($urandom_range(0, 7));
                    POOL_EXTREME: begin
                        case ($urandom_range(0, 2))
                            0:       pool[k] = 16'h0000;
                            1:       pool[k] = 16'hFFFF;
                            default: pool[k] = PAGE_W'($urandom_range(0, 16'hFFFF));
                        endcase
                    end
                    default:       pool[k] = base ^ (16'h0001 << $urandom_range(0, 15));
                endcase
            end
            // about a quarter of the strings run back to back
            no_idle = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 19) == 0)
                    pg = PAGE_W'($urandom_range(0, 16'hFFFF));
                else
                    pg = pool[$urandom_range(0, pool_n - 1)];
                eos = (i == len - 1) && ($urandom_range(0, 9) != 0);
                send_reference(pg, eos);
                sent++;
            end
        end
        no_idle = 1'b0;
    endtask

    // A long run of distinct pages back to back, so each page not already
    // resident faults and the count keeps climbing; then hits on the newest
    // pages, an end mark and a fresh start.
    task automatic test_long_miss_string;
        logic [PAGE_W-1:0] last_page;

        no_idle = 1'b1;
        for (int k = 0; k < MISS_RUN; k++) begin
            last_page = k[PAGE_W-1:0];
            send_reference(last_page, 1'b0);
        end
        no_idle = 1'b0;
        send_reference(last_page, 1'b0);
        send_reference(last_page - 1'b1, 1'b0);
        send_reference(16'hBEEF, 1'b1);
        send_reference(16'hBEEF, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        start           = 1'b0;
        i_page          = '0;
        i_end_of_string = 1'b0;
        i_rst_n         = 1'b0;
        no_idle         = 1'b0;
        error_count     = 0;
        idle_cycles     = 0;
        lru_filled      = 0;
        lru_faults      = '0;
        foreach (lru_age[j]) begin
            lru_age[j]  = '0;
            lru_page[j] = '0;
        end

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_first_reference();
        test_fill_and_hit();
        test_lru_eviction();
        test_end_of_string();
        test_random_strings();
        test_long_miss_string();

        @(negedge i_clk);
        start = 1'b0;

        // drain outstanding results, then idle before the verdict
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
